// File: rtl/table_lookup_interpolator_unit_macros.svh
// assertion macros for the table lookup interpolator
// expects signals clk and rst in the scope of each use
`ifndef TABLE_LOOKUP_INTERPOLATOR_UNIT_MACROS_SVH
`define TABLE_LOOKUP_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define TLI_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define TLI_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/tli_pkg.sv
// shared types and constants of the table lookup interpolator
// no dependencies
package tli_pkg;

  localparam int DATA_W    = 32;
  localparam int SIZE_W    = 13;
  localparam int ADDR_W    = 12;
  localparam int CFG_AW    = 5;
  localparam int S_TDATA_W = 112;
  localparam int M_TDATA_W = 48;

  // word kinds
  localparam logic [1:0] KIND_TABLE  = 2'd0;
  localparam logic [1:0] KIND_XBP    = 2'd1;
  localparam logic [1:0] KIND_YBP    = 2'd2;
  localparam logic [1:0] KIND_LOOKUP = 2'd3;

  // register indexes
  localparam logic [2:0] REG_DIMENSIONS = 3'd0;
  localparam logic [2:0] REG_AXIS_MODES = 3'd1;
  localparam logic [2:0] REG_SIZE_X     = 3'd2;
  localparam logic [2:0] REG_SIZE_Y     = 3'd3;
  localparam logic [2:0] REG_MIN_X      = 3'd4;
  localparam logic [2:0] REG_MAX_X      = 3'd5;
  localparam logic [2:0] REG_MIN_Y      = 3'd6;
  localparam logic [2:0] REG_MAX_Y      = 3'd7;

  typedef struct packed {
    logic [1:0]               dimensions;
    logic [1:0]               axis_modes;
    logic [SIZE_W-1:0]        size_x;
    logic [SIZE_W-1:0]        size_y;
    logic signed [DATA_W-1:0] min_x;
    logic signed [DATA_W-1:0] max_x;
    logic signed [DATA_W-1:0] min_y;
    logic signed [DATA_W-1:0] max_y;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LOC, S_MUL, S_BP0, S_BPN, S_SRCH, S_SRCH_CMP,
    S_DIVGO, S_DIV, S_JMUL, S_RD, S_BL_MUL, S_BL_ADD, S_OUT
  } state_t;

endpackage

// File: rtl/tli_cfg.sv
// configuration register file with its apb-style port
// depends on tli_pkg
module tli_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tli_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output tli_pkg::cfg_t             cfg
);
  import tli_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dimensions <= 2'd1;
      cfg.axis_modes <= 2'd0;
      cfg.size_x     <= SIZE_W'(1);
      cfg.size_y     <= SIZE_W'(1);
      cfg.min_x      <= '0;
      cfg.max_x      <= '0;
      cfg.min_y      <= '0;
      cfg.max_y      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DIMENSIONS: cfg.dimensions <= pwdata[1:0];
        REG_AXIS_MODES: cfg.axis_modes <= pwdata[1:0];
        REG_SIZE_X:     cfg.size_x     <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y:     cfg.size_y     <= pwdata[SIZE_W-1:0];
        REG_MIN_X:      cfg.min_x      <= pwdata;
        REG_MAX_X:      cfg.max_x      <= pwdata;
        REG_MIN_Y:      cfg.min_y      <= pwdata;
        REG_MAX_Y:      cfg.max_y      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIMENSIONS: prdata = {30'b0, cfg.dimensions};
      REG_AXIS_MODES: prdata = {30'b0, cfg.axis_modes};
      REG_SIZE_X:     prdata = {19'b0, cfg.size_x};
      REG_SIZE_Y:     prdata = {19'b0, cfg.size_y};
      REG_MIN_X:      prdata = cfg.min_x;
      REG_MAX_X:      prdata = cfg.max_x;
      REG_MIN_Y:      prdata = cfg.min_y;
      REG_MAX_Y:      prdata = cfg.max_y;
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/tli_mem.sv
// value table and breakpoint memories, one write and one read port each
// depends on tli_pkg
module tli_mem #(
  parameter int TABLE_DEPTH = 4096,
  parameter int AXIS_DEPTH  = 256
) (
  input  logic                           clk,
  input  logic                           tab_we,
  input  logic [$clog2(TABLE_DEPTH)-1:0] tab_waddr,
  input  logic                           bpx_we,
  input  logic                           bpy_we,
  input  logic [$clog2(AXIS_DEPTH)-1:0]  bp_waddr,
  input  logic [tli_pkg::DATA_W-1:0]     wdata,
  input  logic [$clog2(TABLE_DEPTH)-1:0] tab_raddr,
  output logic [tli_pkg::DATA_W-1:0]     tab_rdata,
  input  logic [$clog2(AXIS_DEPTH)-1:0]  bp_raddr,
  output logic [tli_pkg::DATA_W-1:0]     bpx_rdata,
  output logic [tli_pkg::DATA_W-1:0]     bpy_rdata
);
  import tli_pkg::*;

  logic [DATA_W-1:0] tab_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] bpx_mem [AXIS_DEPTH];
  logic [DATA_W-1:0] bpy_mem [AXIS_DEPTH];

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= wdata;
    end
    tab_rdata <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (bpx_we) begin
      bpx_mem[bp_waddr] <= wdata;
    end
    bpx_rdata <= bpx_mem[bp_raddr];
  end

  always_ff @(posedge clk) begin
    if (bpy_we) begin
      bpy_mem[bp_waddr] <= wdata;
    end
    bpy_rdata <= bpy_mem[bp_raddr];
  end

endmodule

// File: rtl/tli_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on tli_pkg
module tli_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  logic [tli_pkg::DATA_W-1:0]                   rem0,
  input  logic [tli_pkg::SIZE_W+FRAC_BITS-1:0]         bits,
  input  logic [$clog2(tli_pkg::SIZE_W+FRAC_BITS+1)-1:0] steps,
  input  logic [tli_pkg::DATA_W-1:0]                   den,
  output logic                                         busy,
  output logic                                         done,
  output logic [tli_pkg::SIZE_W+FRAC_BITS-1:0]         quot
);
  import tli_pkg::*;

  localparam int QW = SIZE_W + FRAC_BITS;
  localparam int SW = $clog2(QW + 1);

  logic [DATA_W-1:0] rem;
  logic [QW-1:0]     sh;
  logic [SW-1:0]     cnt;
  logic [DATA_W:0]   r2;
  logic              ge;
  logic [DATA_W-1:0] rem_next;

  // remainder stays below the divisor, so the trial value fits 33 bits
  assign r2       = {rem, sh[QW-1]};
  assign ge       = r2 >= {1'b0, den};
  assign rem_next = ge ? DATA_W'(r2 - {1'b0, den}) : r2[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == SW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem0;
      sh   <= bits;
      quot <= '0;
      cnt  <= steps;
    end else if (busy) begin
      rem  <= rem_next;
      sh   <= {sh[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], ge};
      cnt  <= cnt - SW'(1);
    end
  end

endmodule

// File: rtl/table_lookup_interpolator_unit.sv
// top level of the table lookup interpolator: sequencer, axis location, blending
// depends on tli_pkg, tli_cfg, tli_mem, tli_div and the assertion macro header
//
// channels: the slave stream carries load and lookup words (tuser = kind),
// the master stream carries one word per lookup, none per load. registers are
// written through the apb-style port; the user must write them only while the
// block is idle, since the block itself does not enforce it. a load word is
// accepted while idle and written to the table or to a breakpoint memory at
// once, so loads stream back to back. a lookup walks each axis in turn. a
// uniform axis is located by the bit-serial divider (index and fraction come
// out of one long division). a breakpoint axis is located by a binary search
// on the breakpoint memory read port, then the fraction division. clamped
// arguments skip the division. then four table reads and up to three
// multiply-add blend steps follow.
// the result waits in an output register; the next word is accepted while
// it waits, and a finished lookup holds in the output state while the
// receiver stalls. reset clears control state and registers; the memories
// hold garbage until written.
`include "table_lookup_interpolator_unit_macros.svh"

module table_lookup_interpolator_unit #(
  parameter int TABLE_DEPTH = 4096,
  parameter int AXIS_DEPTH  = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // address [11:0], load_value [43:12], arg_x [75:44], arg_y [107:76]
  input  logic [tli_pkg::S_TDATA_W-1:0] s_tdata,
  // kind
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // result [31:0], cell_index [43:32]
  output logic [tli_pkg::M_TDATA_W-1:0] m_tdata,
  // error
  output logic                          m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tli_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tli_pkg::*;

  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int AW = $clog2(AXIS_DEPTH);
  localparam int QW = SIZE_W + FRAC_BITS;
  localparam int SW = $clog2(QW + 1);
  localparam int JW = 2 * SIZE_W;
  localparam int NW = DATA_W + 1 + SIZE_W;   // uniform numerator
  localparam int PW = DATA_W + 2 + FRAC_BITS; // blend product

  cfg_t   cfg;
  state_t state, state_next;

  // input word fields
  logic [ADDR_W-1:0]        in_addr;
  logic [DATA_W-1:0]        in_value;
  logic                     accept;

  // configuration views
  logic                     two_d, list_x, list_y;
  logic [SIZE_W-1:0]        nx, ny;
  logic [JW-1:0]            nxy;
  logic                     bad;

  // current axis
  logic                     axis_sel;
  logic                     cur_list;
  logic [SIZE_W-1:0]        cur_n;
  logic signed [DATA_W-1:0] cur_arg, cur_min, cur_max, cur_bp;
  logic signed [DATA_W-1:0] arg_x, arg_y;

  // search and division
  logic [SIZE_W-1:0]        srch_lo, srch_hi, mid_r, mid;
  logic [SIZE_W:0]          mid_sum;
  logic signed [DATA_W-1:0] lo_val, hi_val;
  logic [NW-1:0]            dnum;
  logic [DATA_W-1:0]        dden;
  logic                     duni;
  logic                     div_start, div_busy, div_done;
  logic [QW-1:0]            div_q;
  logic [DATA_W-1:0]        div_rem0;
  logic [QW-1:0]            div_bits;
  logic [SW-1:0]            div_steps;

  // located cells
  logic                     commit;
  logic [SIZE_W-1:0]        commit_idx;
  logic [FRAC_BITS-1:0]     commit_frac;
  logic [SIZE_W-1:0]        idx_x, idx_y;
  logic [FRAC_BITS-1:0]     frac_x, frac_y;

  // table reads and blending
  logic [JW-1:0]            j;
  logic [2:0]               rd_cnt;
  logic [TW-1:0]            tab_raddr;
  logic [DATA_W-1:0]        tab_rdata, bpx_rdata, bpy_rdata;
  logic [AW-1:0]            bp_raddr;
  logic signed [DATA_W-1:0] t0, t1, t2, t3, v1, v2;
  logic [1:0]               bl_cnt;
  logic signed [DATA_W-1:0] bl_a, bl_b, bl_a_r;
  logic [FRAC_BITS-1:0]     bl_f;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     step;
  logic signed [DATA_W-1:0] bl_val;
  logic                     bl_last;

  // result
  logic signed [DATA_W-1:0] res_val;
  logic                     err_r;
  logic                     out_free;

  assign in_addr  = s_tdata[11:0];
  assign in_value = s_tdata[43:12];
  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  tli_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign two_d  = cfg.dimensions[1];
  assign list_x = cfg.axis_modes[0];
  assign list_y = cfg.axis_modes[1];
  assign nx     = (cfg.size_x == '0) ? SIZE_W'(1) : cfg.size_x;
  assign ny     = (cfg.size_y == '0) ? SIZE_W'(1) : cfg.size_y;
  assign nxy    = {{SIZE_W{1'b0}}, nx} * {{SIZE_W{1'b0}}, ny};

  // oversize configuration
  always_comb begin
    bad = list_x && (32'(nx) > 32'(AXIS_DEPTH));
    if (two_d) begin
      bad = bad || (list_y && (32'(ny) > 32'(AXIS_DEPTH))) || (32'(nxy) > 32'(TABLE_DEPTH));
    end else begin
      bad = bad || (32'(nx) > 32'(TABLE_DEPTH));
    end
  end

  assign cur_list = axis_sel ? list_y : list_x;
  assign cur_n    = axis_sel ? ny : nx;
  assign cur_arg  = axis_sel ? arg_y : arg_x;
  assign cur_min  = axis_sel ? cfg.min_y : cfg.min_x;
  assign cur_max  = axis_sel ? cfg.max_y : cfg.max_x;
  assign cur_bp   = axis_sel ? bpy_rdata : bpx_rdata;
  assign mid_sum  = {1'b0, srch_lo} + {1'b0, srch_hi};
  assign mid      = mid_sum[SIZE_W:1];

  tli_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AXIS_DEPTH  (AXIS_DEPTH)
  ) u_mem (
    .clk       (clk),
    .tab_we    (accept && s_tuser == KIND_TABLE && 32'(in_addr) < 32'(TABLE_DEPTH)),
    .tab_waddr (TW'(in_addr)),
    .bpx_we    (accept && s_tuser == KIND_XBP && 32'(in_addr) < 32'(AXIS_DEPTH)),
    .bpy_we    (accept && s_tuser == KIND_YBP && 32'(in_addr) < 32'(AXIS_DEPTH)),
    .bp_waddr  (AW'(in_addr)),
    .wdata     (in_value),
    .tab_raddr (tab_raddr),
    .tab_rdata (tab_rdata),
    .bp_raddr  (bp_raddr),
    .bpx_rdata (bpx_rdata),
    .bpy_rdata (bpy_rdata)
  );

  // uniform axis divides (x - min) * (n - 1) << frac, quotient holds index and fraction;
  // breakpoint axis divides only the fraction
  assign div_rem0  = duni ? DATA_W'(dnum >> SIZE_W) : dnum[DATA_W-1:0];
  assign div_bits  = duni ? {dnum[SIZE_W-1:0], {FRAC_BITS{1'b0}}} : '0;
  assign div_steps = duni ? SW'(QW) : SW'(FRAC_BITS);

  tli_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .rem0  (div_rem0),
    .bits  (div_bits),
    .steps (div_steps),
    .den   (dden),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  // blend operands
  always_comb begin
    case (bl_cnt)
      2'd0: begin
        bl_a = t0;
        bl_b = t1;
        bl_f = two_d ? frac_y : frac_x;
      end
      2'd1: begin
        bl_a = t2;
        bl_b = t3;
        bl_f = frac_y;
      end
      default: begin
        bl_a = v1;
        bl_b = v2;
        bl_f = frac_x;
      end
    endcase
  end

  // arithmetic shift gives the floor of the scaled step
  assign step    = prod >>> FRAC_BITS;
  assign bl_val  = bl_a_r + step[DATA_W-1:0];
  assign bl_last = (bl_cnt == 2'd2) || (bl_cnt == 2'd0 && !two_d);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && s_tuser == KIND_LOOKUP) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK:    state_next = bad ? S_OUT : S_LOC;
      S_LOC: begin
        if (commit) begin
          state_next = (!axis_sel && two_d) ? S_LOC : S_JMUL;
        end else begin
          state_next = cur_list ? S_BP0 : S_MUL;
        end
      end
      S_MUL:      state_next = S_DIVGO;
      S_BP0: begin
        if (commit) begin
          state_next = (!axis_sel && two_d) ? S_LOC : S_JMUL;
        end else begin
          state_next = S_BPN;
        end
      end
      S_BPN: begin
        if (commit) begin
          state_next = (!axis_sel && two_d) ? S_LOC : S_JMUL;
        end else begin
          state_next = S_SRCH;
        end
      end
      S_SRCH:     state_next = (srch_lo + SIZE_W'(1) < srch_hi) ? S_SRCH_CMP : S_DIVGO;
      S_SRCH_CMP: state_next = S_SRCH;
      S_DIVGO:    state_next = S_DIV;
      S_DIV: begin
        if (commit) begin
          state_next = (!axis_sel && two_d) ? S_LOC : S_JMUL;
        end
      end
      S_JMUL:     state_next = S_RD;
      S_RD:       state_next = (rd_cnt == 3'd4) ? S_BL_MUL : S_RD;
      S_BL_MUL:   state_next = S_BL_ADD;
      S_BL_ADD:   state_next = bl_last ? S_OUT : S_BL_MUL;
      S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
      default:    state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    commit      = 1'b0;
    commit_idx  = '0;
    commit_frac = '0;
    div_start   = 1'b0;
    bp_raddr    = AW'(mid);
    case (rd_cnt)
      3'd0:    tab_raddr = TW'(j);
      3'd1:    tab_raddr = TW'(j + JW'(1));
      3'd2:    tab_raddr = TW'(j + JW'(ny));
      default: tab_raddr = TW'(j + JW'(ny) + JW'(1));
    endcase
    unique case (state)
      S_LOC: begin
        bp_raddr = '0;
        if (!cur_list) begin
          if (cur_arg <= cur_min) begin
            commit = 1'b1;
          end else if (cur_arg >= cur_max) begin
            commit     = 1'b1;
            commit_idx = cur_n - SIZE_W'(1);
          end else if (cur_n < SIZE_W'(2)) begin
            commit = 1'b1;
          end
        end
      end
      S_BP0: begin
        bp_raddr = AW'(cur_n - SIZE_W'(1));
        commit   = cur_arg <= cur_bp;
      end
      S_BPN: begin
        commit     = cur_arg >= cur_bp;
        commit_idx = cur_n - SIZE_W'(1);
      end
      S_DIVGO:    div_start = 1'b1;
      S_DIV: begin
        commit      = div_done;
        commit_idx  = duni ? div_q[QW-1:FRAC_BITS] : srch_lo;
        commit_frac = div_q[FRAC_BITS-1:0];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && s_tuser == KIND_LOOKUP) begin
      arg_x    <= s_tdata[75:44];
      arg_y    <= s_tdata[107:76];
      axis_sel <= 1'b0;
      err_r    <= 1'b0;
    end
    if (commit) begin
      if (!axis_sel) begin
        idx_x  <= commit_idx;
        frac_x <= commit_frac;
      end else begin
        idx_y  <= commit_idx;
        frac_y <= commit_frac;
      end
      if (!axis_sel && two_d) begin
        axis_sel <= 1'b1;
      end
    end
    case (state)
      S_CHECK: begin
        if (bad) begin
          err_r   <= 1'b1;
          res_val <= '0;
          j       <= '0;
        end
      end
      S_LOC: begin
        dnum <= NW'({cur_arg[DATA_W-1], cur_arg} - {cur_min[DATA_W-1], cur_min});
        dden <= DATA_W'({cur_max[DATA_W-1], cur_max} - {cur_min[DATA_W-1], cur_min});
      end
      S_MUL: begin
        dnum <= NW'(dnum[DATA_W:0] * (cur_n - SIZE_W'(1)));
        duni <= 1'b1;
      end
      S_BP0:      lo_val <= cur_bp;
      S_BPN: begin
        hi_val  <= cur_bp;
        srch_lo <= '0;
        srch_hi <= cur_n - SIZE_W'(1);
      end
      S_SRCH: begin
        mid_r <= mid;
        dnum  <= NW'({cur_arg[DATA_W-1], cur_arg} - {lo_val[DATA_W-1], lo_val});
        dden  <= DATA_W'({hi_val[DATA_W-1], hi_val} - {lo_val[DATA_W-1], lo_val});
        duni  <= 1'b0;
      end
      S_SRCH_CMP: begin
        if (cur_bp <= cur_arg) begin
          srch_lo <= mid_r;
          lo_val  <= cur_bp;
        end else begin
          srch_hi <= mid_r;
          hi_val  <= cur_bp;
        end
      end
      S_JMUL: begin
        j      <= two_d ? ({{SIZE_W{1'b0}}, idx_x} * {{SIZE_W{1'b0}}, ny} + JW'(idx_y))
                        : JW'(idx_x);
        rd_cnt <= '0;
      end
      S_RD: begin
        rd_cnt <= rd_cnt + 3'd1;
        case (rd_cnt)
          3'd1:    t0 <= tab_rdata;
          3'd2:    t1 <= tab_rdata;
          3'd3:    t2 <= tab_rdata;
          3'd4:    t3 <= tab_rdata;
          default: ;
        endcase
        bl_cnt <= 2'd0;
      end
      S_BL_MUL: begin
        // a zero fraction keeps the lower entry, the upper one may be unwritten
        if (bl_f == '0) begin
          prod <= '0;
        end else begin
          prod <= PW'($signed({bl_b[DATA_W-1], bl_b} - {bl_a[DATA_W-1], bl_a})
                      * $signed({1'b0, bl_f}));
        end
        bl_a_r <= bl_a;
      end
      S_BL_ADD: begin
        case (bl_cnt)
          2'd0:    v1 <= bl_val;
          2'd1:    v2 <= bl_val;
          default: ;
        endcase
        if (bl_last) begin
          res_val <= bl_val;
        end
        bl_cnt <= bl_cnt + 2'd1;
      end
      default: ;
    endcase
    if (state == S_OUT && out_free) begin
      m_tdata <= {4'b0, j[ADDR_W-1:0], res_val};
      m_tuser <= err_r;
    end
  end

  // checks
  `TLI_ASSERT_IMP(a_err_word_zero, m_tvalid && m_tuser, m_tdata == '0, "error word not zero")
  `TLI_ASSERT_IMP(a_div_in_state, div_busy, state == S_DIV, "divider busy outside divide")
  `TLI_ASSERT_NXT(a_lookup_starts, accept && s_tuser == KIND_LOOKUP, state == S_CHECK,
    "lookup not started")

endmodule
